### hw/rtl/ffa_pkg.sv
// Shared types, codes and defaults for the first-free allocator.
`timescale 1ns / 1ps

package ffa_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_SLOTS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Fixed field widths
    localparam int SLOT_W = 5;
    localparam int CFG_W  = 5;
    localparam int CMP_W  = 8;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        KIND_GRANTED  = 3'd0,
        KIND_QUEUED   = 3'd1,
        KIND_RELEASED = 3'd2,
        KIND_IGNORED  = 3'd3,
        KIND_REJECTED = 3'd4
    } kind_t;

    // Slot table commands and status
    typedef struct packed {
        logic alloc;
        logic free_slot;
        logic regrant;
    } slot_cmd_t;

    typedef struct packed {
        logic any_free;
        logic rel_ok;
    } slot_stat_t;

    // Wait queue commands and status
    typedef struct packed {
        logic push;
        logic pop;
    } queue_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

### hw/rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ffa_slot_table.sv
// Slot busy flags, lowest-free search, release match and owner store.
`timescale 1ns / 1ps

module ffa_slot_table #(
    parameter int  MAX_SLOTS = ffa_pkg::MAX_SLOTS_DEF,
    parameter int  ID_BITS   = ffa_pkg::ID_BITS_DEF,
    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ffa_pkg::CFG_W-1:0] slots_in_use,
    input  ffa_pkg::slot_cmd_t       cmd,
    input  logic [ffa_pkg::SLOT_W-1:0] cmd_slot,
    input  logic [ID_BITS-1:0]       alloc_id,
    input  logic [ID_BITS-1:0]       regrant_id,
    input  logic                     rd_en,
    input  logic [ffa_pkg::SLOT_W-1:0] rd_slot,
    output ffa_pkg::slot_stat_t      stat,
    output logic [SLOT_AW-1:0]       free_idx,
    output logic [ID_BITS-1:0]       owner_q
);

    import ffa_pkg::*;

    localparam int SXW = (SLOT_AW > SLOT_W) ? SLOT_AW : SLOT_W;

    logic [MAX_SLOTS-1:0] busy_reg;
    logic [MAX_SLOTS-1:0] busy_next;
    logic [MAX_SLOTS-1:0] free_vec;
    logic [MAX_SLOTS-1:0] hit_vec;
    logic [CMP_W-1:0]     lim;
    logic [SXW-1:0]       cmd_m1;
    logic [SXW-1:0]       rd_m1;
    logic [SLOT_AW-1:0]   cmd_idx;
    logic [SLOT_AW-1:0]   rd_idx;
    logic                 wr_en;
    logic [SLOT_AW-1:0]   wr_addr;
    logic [ID_BITS-1:0]   wr_data;
    logic [ID_BITS-1:0]   ram_q;
    logic                 byp_hit_reg;
    logic [ID_BITS-1:0]   byp_data_reg;

    // Clip the slot count to the table size
    always_comb
    begin
        if (CMP_W'(slots_in_use) > CMP_W'(MAX_SLOTS))
        begin
            lim = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            lim = CMP_W'(slots_in_use);
        end
    end

    // Slot numbers start at one; turn them into table indexes
    assign cmd_m1  = SXW'(cmd_slot) - SXW'(1);
    assign rd_m1   = SXW'(rd_slot) - SXW'(1);
    assign cmd_idx = cmd_m1[SLOT_AW-1:0];
    assign rd_idx  = rd_m1[SLOT_AW-1:0];

    // Flag free slots and the busy slot named by a release
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            free_vec[i] = !busy_reg[i] && (CMP_W'(i) < lim);
            hit_vec[i]  = busy_reg[i] && (CMP_W'(i) < lim)
                          && (CMP_W'(i + 1) == CMP_W'(cmd_slot));
        end
    end

    // Pick the lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = SLOT_AW'(i);
            end
        end
    end

    assign stat.any_free = |free_vec;
    assign stat.rel_ok   = |hit_vec;

    // Set on allocation, clear on a release nobody waits for
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            busy_next[i] = busy_reg[i];
            if (cmd.alloc && (free_idx == SLOT_AW'(i)))
            begin
                busy_next[i] = 1'b1;
            end
            if (cmd.free_slot && (cmd_idx == SLOT_AW'(i)))
            begin
                busy_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Owner store: write on a grant, read ahead for an incoming release
    assign wr_en   = cmd.alloc || cmd.regrant;
    assign wr_addr = cmd.alloc ? free_idx : cmd_idx;
    assign wr_data = cmd.alloc ? alloc_id : regrant_id;

    ffa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (ram_q)
    );

    // Forward an owner written in the same cycle as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    assign owner_q = byp_hit_reg ? byp_data_reg : ram_q;

endmodule

### hw/rtl/ffa_wait_queue.sv
// Circular wait queue of requester ids with look-ahead head read.
`timescale 1ns / 1ps

module ffa_wait_queue #(
    parameter int QUEUE_DEPTH = ffa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ffa_pkg::ID_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffa_pkg::queue_cmd_t  cmd,
    input  logic [ID_BITS-1:0]   push_data,
    input  logic                 rd_en,
    output ffa_pkg::queue_stat_t stat,
    output logic [ID_BITS-1:0]   head_q
);

    import ffa_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW = QCW + 1;

    logic [QAW-1:0]     head_reg;
    logic [QAW-1:0]     head_next;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    logic [QSW-1:0]     tail_sum;
    logic [QSW-1:0]     tail_wrap;
    logic [QAW-1:0]     tail;
    logic [ID_BITS-1:0] ram_q;
    logic               byp_hit_reg;
    logic [ID_BITS-1:0] byp_data_reg;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QUEUE_DEPTH));

    // Tail position, wrapped once at most
    assign tail_sum  = QSW'(head_reg) + QSW'(count_reg);
    assign tail_wrap = (tail_sum >= QSW'(QUEUE_DEPTH)) ? (tail_sum - QSW'(QUEUE_DEPTH))
                                                       : tail_sum;
    assign tail      = tail_wrap[QAW-1:0];

    // Advance head on a pop, adjust fill count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            if (head_reg == QAW'(QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + QAW'(1);
            end
            count_next = count_reg - QCW'(1);
        end
        if (cmd.push)
        begin
            count_next = count_reg + QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Queue store: push at the tail, read the head the next item will see
    ffa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail),
        .wr_data (push_data),
        .rd_en   (rd_en),
        .rd_addr (head_next),
        .rd_data (ram_q)
    );

    // Forward an id pushed into an empty queue in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= cmd.push && (tail == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= push_data;
        end
    end

    assign head_q = byp_hit_reg ? byp_data_reg : ram_q;

endmodule

### hw/rtl/first_free_allocator_with_waitlist_core.sv
// Top level of the first-free slot allocator with a FIFO wait list.
`timescale 1ns / 1ps

// Slot allocator: a request takes the lowest-numbered free slot among
// 1..slots_in_use, clipped to MAX_SLOTS, or joins a FIFO wait list, or is
// rejected when the list is full; a release of a busy slot reports the
// leaving owner and, when someone waits, hands the slot straight to the head
// of the list. An accepted item is held in the input register, is decided
// there once the output buffer is empty or draining, and is then written to
// the output buffer, which presents its first result word; one item is
// accepted per cycle while the receiver keeps up. A release that wakes a
// waiter produces two words; the two-word output buffer sends the release
// word and then the grant, and the next item waits while the second word
// drains. Owner ids and waiting ids sit in two RAMs read when an item is
// accepted, ahead of its decision, with forwarding for a write from the item
// just ahead. slots_in_use may be changed only while the block is idle.

module first_free_allocator_with_waitlist_core #(
    parameter int MAX_SLOTS   = ffa_pkg::MAX_SLOTS_DEF,
    parameter int QUEUE_DEPTH = ffa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ffa_pkg::ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_write_en,
    input  logic [ffa_pkg::CFG_W-1:0]   cfg_write_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ffa_pkg::req_t               req_type,
    input  logic [ID_BITS-1:0]          requester_id,
    input  logic [ffa_pkg::SLOT_W-1:0]  slot_number,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output ffa_pkg::kind_t              result_kind,
    output logic [ID_BITS-1:0]          owner_id,
    output logic [ffa_pkg::SLOT_W-1:0]  slot_index,
    output logic                        last_result
);

    import ffa_pkg::*;

    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [CFG_W-1:0]  slots_in_use_reg;

    logic              in_valid_reg;
    logic              in_valid_next;
    req_t              type_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              in_take;
    logic              out_take;
    logic              fire;
    logic              is_req;

    slot_cmd_t         s_cmd;
    slot_stat_t        s_stat;
    queue_cmd_t        q_cmd;
    queue_stat_t       q_stat;
    logic [SLOT_AW-1:0] free_idx;
    logic [ID_BITS-1:0] owner_q;
    logic [ID_BITS-1:0] head_q;

    // new result words
    logic [1:0]        new_cnt;
    kind_t             n0_kind;
    logic [ID_BITS-1:0] n0_owner;
    logic [SLOT_W-1:0] n0_slot;
    logic              n0_last;
    kind_t             n1_kind;
    logic [ID_BITS-1:0] n1_owner;

    // output buffer
    logic [1:0]        ob_cnt_reg;
    logic [1:0]        ob_cnt_next;
    kind_t             w0_kind_reg, w0_kind_next;
    logic [ID_BITS-1:0] w0_owner_reg, w0_owner_next;
    logic [SLOT_W-1:0] w0_slot_reg, w0_slot_next;
    logic              w0_last_reg, w0_last_next;
    kind_t             w1_kind_reg, w1_kind_next;
    logic [ID_BITS-1:0] w1_owner_reg, w1_owner_next;
    logic [SLOT_W-1:0] w1_slot_reg, w1_slot_next;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
        end
        else if (cfg_write_en)
        begin
            slots_in_use_reg <= cfg_write_data;
        end
    end

    // Handshakes: decide when the buffer is empty or drains this cycle
    assign out_take = out_valid && !out_stall;
    assign fire     = in_valid_reg
                      && ((ob_cnt_reg == 2'd0) || ((ob_cnt_reg == 2'd1) && out_take));
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            type_reg <= req_type;
            id_reg   <= requester_id;
            slot_reg <= slot_number;
        end
    end

    // Decide what the held word does to slots and queue
    assign is_req = (type_reg == REQ_ALLOC);

    always_comb
    begin
        s_cmd.alloc     = fire && is_req && s_stat.any_free;
        s_cmd.free_slot = fire && !is_req && s_stat.rel_ok && q_stat.empty;
        s_cmd.regrant   = fire && !is_req && s_stat.rel_ok && !q_stat.empty;
        q_cmd.push      = fire && is_req && !s_stat.any_free && !q_stat.full;
        q_cmd.pop       = s_cmd.regrant;
    end

    ffa_slot_table #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .slots_in_use (slots_in_use_reg),
        .cmd          (s_cmd),
        .cmd_slot     (slot_reg),
        .alloc_id     (id_reg),
        .regrant_id   (head_q),
        .rd_en        (in_take),
        .rd_slot      (slot_number),
        .stat         (s_stat),
        .free_idx     (free_idx),
        .owner_q      (owner_q)
    );

    ffa_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .push_data (id_reg),
        .rd_en     (in_take),
        .stat      (q_stat),
        .head_q    (head_q)
    );

    // Build the result words for the held item
    always_comb
    begin
        new_cnt  = 2'd1;
        n0_kind  = KIND_IGNORED;
        n0_owner = '0;
        n0_slot  = '0;
        n0_last  = 1'b1;
        n1_kind  = KIND_GRANTED;
        n1_owner = head_q;
        if (is_req)
        begin
            n0_owner = id_reg;
            if (s_stat.any_free)
            begin
                n0_kind = KIND_GRANTED;
                n0_slot = SLOT_W'(free_idx) + SLOT_W'(1);
            end
            else if (!q_stat.full)
            begin
                n0_kind = KIND_QUEUED;
            end
            else
            begin
                n0_kind = KIND_REJECTED;
            end
        end
        else if (s_stat.rel_ok)
        begin
            n0_kind  = KIND_RELEASED;
            n0_owner = owner_q;
            n0_slot  = slot_reg;
            if (!q_stat.empty)
            begin
                n0_last = 1'b0;
                new_cnt = 2'd2;
            end
        end
    end

    // Output buffer: drain a word, shift the second up, load on decide
    always_comb
    begin
        ob_cnt_next   = ob_cnt_reg;
        w0_kind_next  = w0_kind_reg;
        w0_owner_next = w0_owner_reg;
        w0_slot_next  = w0_slot_reg;
        w0_last_next  = w0_last_reg;
        w1_kind_next  = w1_kind_reg;
        w1_owner_next = w1_owner_reg;
        w1_slot_next  = w1_slot_reg;
        if (out_take)
        begin
            if (ob_cnt_reg == 2'd2)
            begin
                ob_cnt_next   = 2'd1;
                w0_kind_next  = w1_kind_reg;
                w0_owner_next = w1_owner_reg;
                w0_slot_next  = w1_slot_reg;
                w0_last_next  = 1'b1;
            end
            else
            begin
                ob_cnt_next = 2'd0;
            end
        end
        if (fire)
        begin
            ob_cnt_next   = new_cnt;
            w0_kind_next  = n0_kind;
            w0_owner_next = n0_owner;
            w0_slot_next  = n0_slot;
            w0_last_next  = n0_last;
            w1_kind_next  = n1_kind;
            w1_owner_next = n1_owner;
            w1_slot_next  = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_kind_reg  <= w0_kind_next;
        w0_owner_reg <= w0_owner_next;
        w0_slot_reg  <= w0_slot_next;
        w0_last_reg  <= w0_last_next;
        w1_kind_reg  <= w1_kind_next;
        w1_owner_reg <= w1_owner_next;
        w1_slot_reg  <= w1_slot_next;
    end

    assign out_valid   = (ob_cnt_reg != 2'd0);
    assign result_kind = w0_kind_reg;
    assign owner_id    = w0_owner_reg;
    assign slot_index  = w0_slot_reg;
    assign last_result = w0_last_reg;

endmodule

### tb/ffa_checker.sv
// Checker for the first-free allocator: predicts result words and compares them.
`timescale 1ns / 1ps

module ffa_checker #(
    parameter int MAX_SLOTS   = ffa_pkg::MAX_SLOTS_DEF,
    parameter int QUEUE_DEPTH = ffa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ffa_pkg::ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [ffa_pkg::CFG_W-1:0]   cfg_write_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  ffa_pkg::req_t               req_type,
    input  logic [ID_BITS-1:0]          requester_id,
    input  logic [ffa_pkg::SLOT_W-1:0]  slot_number,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  ffa_pkg::kind_t              result_kind,
    input  logic [ID_BITS-1:0]          owner_id,
    input  logic [ffa_pkg::SLOT_W-1:0]  slot_index,
    input  logic                        last_result,
    output int                          fail_count,
    output int                          words_pending
);

    import ffa_pkg::*;

    typedef struct packed {
        kind_t               kind;
        logic [ID_BITS-1:0]  owner;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } alloc_word_t;

    // Shadow of the allocator state
    logic [MAX_SLOTS-1:0] busy_map;
    logic [ID_BITS-1:0]   owner_of [MAX_SLOTS];
    logic [ID_BITS-1:0]   waiters [QUEUE_DEPTH];
    int unsigned          wait_head;
    int unsigned          wait_count;
    logic [CFG_W-1:0]     slot_count;
    alloc_word_t          expected_words [$];

    function automatic alloc_word_t make_word(kind_t k, logic [ID_BITS-1:0] o, int s,
                                              logic l);
        alloc_word_t w;
        w.kind  = k;
        w.owner = o;
        w.slot  = SLOT_W'(s);
        w.last  = l;
        return w;
    endfunction

    // Append one predicted word to the tail of the expectation list
    function automatic void add_expected(alloc_word_t w);
        expected_words = {expected_words, w};
    endfunction

    // Advance the shadow state by one accepted word and queue what it yields
    task automatic predict_allocation(input req_t op, input logic [ID_BITS-1:0] id,
                                      input logic [SLOT_W-1:0] sn);
        int limit;
        int hit;
        limit = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
        if (op == REQ_ALLOC) begin
            hit = -1;
            for (int i = limit - 1; i >= 0; i--)
                if (!busy_map[i])
                    hit = i;
            if (hit >= 0) begin
                busy_map[hit] = 1'b1;
                owner_of[hit] = id;
                add_expected(make_word(KIND_GRANTED, id, hit + 1, 1'b1));
            end else if (wait_count < QUEUE_DEPTH) begin
                waiters[(wait_head + wait_count) % QUEUE_DEPTH] = id;
                wait_count++;
                add_expected(make_word(KIND_QUEUED, id, 0, 1'b1));
            end else begin
                add_expected(make_word(KIND_REJECTED, id, 0, 1'b1));
            end
        end else begin
            if (sn == 0 || sn > limit || !busy_map[sn-1]) begin
                add_expected(make_word(KIND_IGNORED, '0, 0, 1'b1));
            end else if (wait_count == 0) begin
                busy_map[sn-1] = 1'b0;
                add_expected(make_word(KIND_RELEASED, owner_of[sn-1], sn, 1'b1));
            end else begin
                // hand the slot straight to the head of the wait list
                add_expected(make_word(KIND_RELEASED, owner_of[sn-1], sn, 1'b0));
                owner_of[sn-1] = waiters[wait_head];
                wait_head = (wait_head + 1) % QUEUE_DEPTH;
                wait_count--;
                add_expected(make_word(KIND_GRANTED, owner_of[sn-1], sn, 1'b1));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        alloc_word_t seen;
        alloc_word_t want;
        if (!rst_n)
        begin
            busy_map = '0;
            wait_head = 0;
            wait_count = 0;
            slot_count = SLOTS_RESET;
            expected_words.delete();
            fail_count = 0;
            words_pending = 0;
        end
        else
        begin
            // Compare the result word first: it never stems from this edge's input
            if (out_valid && !out_stall)
            begin
                seen = {result_kind, owner_id, slot_index, last_result};
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: unexpected word kind=%0d owner=%0d slot=%0d last=%0d",
                                 $realtime, seen.kind, seen.owner, seen.slot, seen.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%t: mismatch expected kind=%0d owner=%0d slot=%0d ",
                                      "last=%0d, got kind=%0d owner=%0d slot=%0d last=%0d"},
                                     $realtime, want.kind, want.owner, want.slot, want.last,
                                     seen.kind, seen.owner, seen.slot, seen.last);
                    end
                end
            end
            // Take the register write and the accepted input word
            if (cfg_write_en)
                slot_count = cfg_write_data;
            if (in_valid && !in_stall)
                predict_allocation(req_type, requester_id, slot_number);
            words_pending = expected_words.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for the first-free allocator: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_top;

    import ffa_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [CFG_W-1:0]    cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    req_t                req_type = REQ_ALLOC;
    logic [7:0]          requester_id = '0;
    logic [SLOT_W-1:0]   slot_number = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    kind_t               result_kind;
    logic [7:0]          owner_id;
    logic [SLOT_W-1:0]   slot_index;
    logic                last_result;
    int                  fail_count;
    int                  words_pending;

    // Idling controls and receiver hold-off requests
    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;
    int                  hold_asked = 0;
    int                  hold_served = 0;

    first_free_allocator_with_waitlist_core DUT (.*);

    ffa_checker CHK (.*);

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin : rx_proc
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                out_stall <= 1'b1;
                held = 0;
                while (held < 80)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_served++;
                out_stall <= 1'b0;
            end
            else if (rx_idle_on)
                out_stall <= ($urandom_range(99) < 35);
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one word, with an optional gap ahead of it; return at acceptance
    task automatic send_word(input req_t op, input logic [7:0] id, input logic [SLOT_W-1:0] sn);
        int gap;
        if (tx_idle_on && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        requester_id <= id;
        slot_number <= sn;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain the block, then write the slot count
    task automatic set_slot_count(input logic [CFG_W-1:0] count);
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= count;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Random word: release mostly within the live slots, else any slot number
    task automatic send_random(input int alloc_pct, input logic [CFG_W-1:0] count);
        int lim;
        lim = (count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(count);
        if ($urandom_range(99) < alloc_pct)
            send_word(REQ_ALLOC, 8'($urandom_range(255)), '0);
        else if (lim > 0 && $urandom_range(99) < 85)
            send_word(REQ_FREE, 8'($urandom), SLOT_W'($urandom_range(1, lim)));
        else
            send_word(REQ_FREE, 8'($urandom), SLOT_W'($urandom_range(0, 31)));
    endtask

    initial
    begin : stim_proc
        logic [CFG_W-1:0] counts [10];
        int               pcts [3];
        counts = '{5'd4, 5'd1, 5'd16, 5'd2, 5'd31, 5'd8, 5'd0, 5'd3, 5'd16, 5'd0};
        counts[9] = CFG_W'($urandom_range(1, 16));
        pcts = '{70, 55, 40};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Two slots: unknown and free releases, grants, a waiter, hand-over
        set_slot_count(5'd2);
        send_word(REQ_FREE, 8'h00, 5'd0);
        send_word(REQ_FREE, 8'h00, 5'd1);
        send_word(REQ_ALLOC, 8'h00, 5'd0);
        send_word(REQ_ALLOC, 8'hFF, 5'd31);
        send_word(REQ_ALLOC, 8'hA5, 5'd0);
        send_word(REQ_FREE, 8'h00, 5'd3);
        send_word(REQ_FREE, 8'hFF, 5'd31);
        send_word(REQ_FREE, 8'h00, 5'd1);
        send_word(REQ_ALLOC, 8'h5A, 5'd0);
        // Widen to four: a new request jumps ahead of the waiter
        set_slot_count(5'd4);
        send_word(REQ_ALLOC, 8'h3C, 5'd0);
        send_word(REQ_FREE, 8'h00, 5'd2);
        send_word(REQ_FREE, 8'h00, 5'd2);
        // Narrow to one: slot three stays busy but out of reach
        set_slot_count(5'd1);
        send_word(REQ_FREE, 8'h00, 5'd3);
        send_word(REQ_ALLOC, 8'h11, 5'd0);
        // No slots at all
        set_slot_count(5'd0);
        send_word(REQ_ALLOC, 8'h22, 5'd0);
        send_word(REQ_FREE, 8'h00, 5'd1);
        // Count above the maximum acts as the maximum
        set_slot_count(5'd31);
        send_word(REQ_FREE, 8'h00, 5'd3);
        send_word(REQ_FREE, 8'h00, 5'd16);
        send_word(REQ_FREE, 8'h00, 5'd17);

        // Random phases over several slot counts
        for (int p = 0; p < 10; p++)
        begin
            set_slot_count(counts[p]);
            if (p == 3)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (p == 5)
            begin
                tx_idle_on = 1'b0;
                hold_asked++;
            end
            for (int n = 0; n < 128; n++)
                send_random(pcts[p % 3], counts[p]);
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("** first_free_allocator_with_waitlist_core: PASSED **");
        else
            $display("** first_free_allocator_with_waitlist_core: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("** first_free_allocator_with_waitlist_core: FAILED **");
        $finish;
    end

endmodule
